FILE: hw/rtl/bcsm_pkg.sv
// ----------------------------------------------------------------------------
// bcsm_pkg
// Shared types and constants of the battery charge state monitor: state
// codes, charger status codes, register indexes and the discharge curve.
// ----------------------------------------------------------------------------
package bcsm_pkg;

	localparam int CURVE_LEN = 102;

	// monitor state codes
	localparam logic [2:0] ST_DISCHARGING = 3'd0;
	localparam logic [2:0] ST_CHARGING    = 3'd1;
	localparam logic [2:0] ST_CHARGED     = 3'd2;
	localparam logic [2:0] ST_LOW         = 3'd3;
	localparam logic [2:0] ST_FAIL        = 3'd4;

	// charger status codes
	localparam logic [2:0] CHG_READ_FAIL = 3'd0;
	localparam logic [2:0] CHG_READY     = 3'd1;
	localparam logic [2:0] CHG_CHARGING  = 3'd2;
	localparam logic [2:0] CHG_CHARGED   = 3'd3;
	localparam logic [2:0] CHG_FAULT     = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_SCALE_GAIN    = 2'd0;
	localparam logic [1:0] REG_SCALE_DIVISOR = 2'd1;
	localparam logic [1:0] REG_LOW_INDEX     = 2'd2;
	localparam logic [1:0] REG_SHUTOFF_MV    = 2'd3;

	localparam logic [6:0]  ON_CHARGER_LEVEL   = 7'd101;
	localparam logic [6:0]  PERCENT_MAX        = 7'd100;
	localparam logic [6:0]  LOW_INDEX_MAX      = 7'd97;
	localparam logic [16:0] FAIL_HYSTERESIS_MV = 17'd50;
	localparam logic [15:0] VOLT_SAT           = 16'hFFFF;

	typedef struct packed {
		logic [2:0] state;
		logic [6:0] held_level;
	} state_rec_t;

	localparam state_rec_t STATE_RESET = '{state: ST_DISCHARGING, held_level: ON_CHARGER_LEVEL};

	localparam logic [15:0] CURVE_MV [CURVE_LEN] = '{
		16'd3000,
		16'd3000, 16'd3269, 16'd3368, 16'd3437, 16'd3493, 16'd3536, 16'd3568, 16'd3596,
		16'd3621, 16'd3636, 16'd3655, 16'd3659, 16'd3662, 16'd3666, 16'd3669, 16'd3672,
		16'd3675, 16'd3678, 16'd3681, 16'd3684, 16'd3688, 16'd3691, 16'd3695, 16'd3698,
		16'd3702, 16'd3706, 16'd3710, 16'd3714, 16'd3718, 16'd3722, 16'd3725, 16'd3729,
		16'd3733, 16'd3737, 16'd3740, 16'd3744, 16'd3747, 16'd3751, 16'd3754, 16'd3757,
		16'd3760, 16'd3763, 16'd3765, 16'd3768, 16'd3771, 16'd3773, 16'd3776, 16'd3778,
		16'd3780, 16'd3783, 16'd3785, 16'd3788, 16'd3790, 16'd3793, 16'd3796, 16'd3798,
		16'd3801, 16'd3805, 16'd3808, 16'd3811, 16'd3815, 16'd3819, 16'd3823, 16'd3827,
		16'd3832, 16'd3836, 16'd3841, 16'd3846, 16'd3852, 16'd3857, 16'd3863, 16'd3868,
		16'd3874, 16'd3880, 16'd3886, 16'd3893, 16'd3899, 16'd3905, 16'd3911, 16'd3917,
		16'd3923, 16'd3929, 16'd3935, 16'd3941, 16'd3947, 16'd3953, 16'd3958, 16'd3964,
		16'd3969, 16'd3975, 16'd3981, 16'd3986, 16'd3993, 16'd3999, 16'd4006, 16'd4014,
		16'd4022, 16'd4031, 16'd4042, 16'd4050,
		16'hFFFF
	};

	function automatic logic [15:0] curve_at(input logic [6:0] addr);
		logic [15:0] val;
		val = VOLT_SAT;
		if (int'(addr) < CURVE_LEN) begin
			val = CURVE_MV[addr];
		end
		return val;
	endfunction

endpackage

FILE: hw/rtl/bcsm_curve_rom.sv
// ----------------------------------------------------------------------------
// bcsm_curve_rom
// Discharge curve ROM, one registered read per cycle.
// ----------------------------------------------------------------------------
module bcsm_curve_rom
	import bcsm_pkg::*;
(
	input  logic        clk,
	input  logic [6:0]  addr,
	output logic [15:0] data
);

	logic [15:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= curve_at(addr);
	end

	assign data = data_q;

endmodule

FILE: hw/rtl/bcsm_state_mem.sv
// ----------------------------------------------------------------------------
// bcsm_state_mem
// Single-entry state memory holding the monitor state and held level.
// Synchronous registered read; reads the reset record until written.
// ----------------------------------------------------------------------------
module bcsm_state_mem
	import bcsm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       re,
	input  logic       we,
	input  state_rec_t wdata,
	output state_rec_t rdata
);

	state_rec_t mem_q [1];
	state_rec_t rdata_q;
	logic       vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (we) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[0] <= wdata;
		end
		if (re) begin
			rdata_q <= vld_q ? mem_q[0] : STATE_RESET;
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/bcsm_scale.sv
// ----------------------------------------------------------------------------
// bcsm_scale
// ADC count to millivolts: count * gain / divisor, saturated to 16 bits.
// A multiply step, a saturation check, then a 16-step restoring divider.
// ----------------------------------------------------------------------------
module bcsm_scale
	import bcsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [12:0] adc_count,
	input  logic [19:0] gain,
	input  logic [19:0] divisor,
	output logic        done,
	output logic [15:0] voltage
);

	typedef enum logic [3:0] {
		SC_IDLE = 4'b0001,
		SC_MUL  = 4'b0010,
		SC_CHK  = 4'b0100,
		SC_DIV  = 4'b1000
	} sc_state_t;

	sc_state_t   st_q;
	logic [11:0] mag_q;
	logic [19:0] gain_q;
	logic [19:0] div_q;
	logic [31:0] prod_q;
	logic [19:0] rem_q;
	logic [15:0] quo_q;
	logic [3:0]  cnt_q;
	logic        done_q;

	logic [20:0] rem_sh;
	logic        qbit;
	logic        sat;

	assign rem_sh = {rem_q, quo_q[15]};
	assign qbit   = rem_sh >= {1'b0, div_q};
	assign sat    = {4'd0, prod_q[31:16]} >= div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SC_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			case (st_q)
				SC_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						st_q <= SC_MUL;
					end
				end
				SC_MUL: begin
					done_q <= 1'b0;
					st_q   <= SC_CHK;
				end
				SC_CHK: begin
					cnt_q  <= '0;
					done_q <= sat;
					if (sat) begin
						st_q <= SC_IDLE;
					end else begin
						st_q <= SC_DIV;
					end
				end
				SC_DIV: begin
					cnt_q  <= cnt_q + 4'd1;
					done_q <= (cnt_q == 4'd15);
					if (cnt_q == 4'd15) begin
						st_q <= SC_IDLE;
					end
				end
				default: begin
					done_q <= 1'b0;
					st_q   <= SC_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			SC_IDLE: begin
				if (start) begin
					// negative counts read as zero volts
					mag_q  <= adc_count[12] ? 12'd0 : adc_count[11:0];
					gain_q <= gain;
					div_q  <= (divisor == 20'd0) ? 20'd1 : divisor;
				end
			end
			SC_MUL: begin
				prod_q <= 32'(mag_q * gain_q);
			end
			SC_CHK: begin
				if (sat) begin
					quo_q <= VOLT_SAT;
				end else begin
					rem_q <= {4'd0, prod_q[31:16]};
					quo_q <= prod_q[15:0];
				end
			end
			SC_DIV: begin
				rem_q <= qbit ? 20'(rem_sh - {1'b0, div_q}) : rem_sh[19:0];
				quo_q <= {quo_q[14:0], qbit};
			end
			default: begin
			end
		endcase
	end

	assign done    = done_q;
	assign voltage = quo_q;

endmodule

FILE: hw/rtl/battery_charge_state_monitor.sv
// ----------------------------------------------------------------------------
// battery_charge_state_monitor
// Converts a battery ADC sample to millivolts and percent, and runs the
// charge state machine whose state and held level live in a state memory.
//
//  group   dir  beat contents
//  s_*     in   adc_count, charger_status, charger_connected
//  m_*     out  battery_state, voltage_mv, percent_remaining, reported_level,
//               level_changed, charger_present
//  cfg_*   in   register write: scale_gain, scale_divisor, low_index, shutoff_mv
//
// One beat at a time: the 16-step divider (skipped on saturation) plus the
// curve walk, one ROM entry per cycle, dominate the time from accept to
// result. A new beat is taken while a result waits in the output register;
// the update stalls only if that register is still full. Reset is
// asynchronous; state memory reads discharging, level 101 until first
// written.
// ----------------------------------------------------------------------------
module battery_charge_state_monitor
	import bcsm_pkg::*;
#(
	parameter int TABLE_ENTRIES = 102
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [12:0] adc_count, [15:13] charger_status, [16] charger_connected
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] battery_state, [18:3] voltage_mv, [25:19] percent_remaining,
	// [32:26] reported_level, [33] level_changed, [34] charger_present
	output logic [39:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_wdata
);

	localparam int         SEARCH_LIMIT = (TABLE_ENTRIES < CURVE_LEN) ? TABLE_ENTRIES : CURVE_LEN;
	localparam logic [6:0] LIMIT_IDX    = 7'(SEARCH_LIMIT);

	typedef enum logic [5:0] {
		T_IDLE  = 6'b000001,
		T_SCALE = 6'b000010,
		T_SRCH0 = 6'b000100,
		T_SRCH  = 6'b001000,
		T_LOWRD = 6'b010000,
		T_UPD   = 6'b100000
	} top_state_t;

	top_state_t  st_q;
	logic [19:0] scale_gain_q;
	logic [19:0] scale_divisor_q;
	logic [6:0]  low_index_q;
	logic [15:0] shutoff_mv_q;

	logic [2:0]  status_q;
	logic        connected_q;
	logic [15:0] volt_q;
	logic [6:0]  cmp_idx_q;
	logic [6:0]  pct_q;
	logic        m_tvalid_q;
	logic [39:0] m_tdata_q;

	logic        accept;
	logic        scale_done;
	logic [15:0] scale_volt;
	logic [6:0]  rom_addr;
	logic [15:0] rom_data;
	logic        mem_re;
	logic        mem_we;
	state_rec_t  mem_rd;
	state_rec_t  mem_wr;
	logic        upd_go;

	logic [6:0]  lo;
	logic        en;
	logic        present;
	logic [15:0] v;
	logic [6:0]  p_n;
	logic [6:0]  held_n;
	logic [2:0]  next_st;
	logic        changed;

	assign s_tready = (st_q == T_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign mem_re   = accept;
	assign upd_go   = (st_q == T_UPD) && (!m_tvalid_q || m_tready);
	assign mem_we   = upd_go;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_gain_q    <= 20'd7200;
			scale_divisor_q <= 20'd4096;
			low_index_q     <= 7'd2;
			shutoff_mv_q    <= 16'd2600;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE_GAIN:    scale_gain_q    <= cfg_wdata;
				REG_SCALE_DIVISOR: scale_divisor_q <= cfg_wdata;
				REG_LOW_INDEX:     low_index_q     <= cfg_wdata[6:0];
				REG_SHUTOFF_MV:    shutoff_mv_q    <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	bcsm_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.adc_count (s_tdata[12:0]),
		.gain      (scale_gain_q),
		.divisor   (scale_divisor_q),
		.done      (scale_done),
		.voltage   (scale_volt)
	);

	bcsm_curve_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	bcsm_state_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (mem_re),
		.we     (mem_we),
		.wdata  (mem_wr),
		.rdata  (mem_rd)
	);

	assign lo = (low_index_q > LOW_INDEX_MAX) ? LOW_INDEX_MAX : low_index_q;

	always_comb begin
		case (st_q)
			T_SRCH:  rom_addr = cmp_idx_q + 7'd1;
			T_LOWRD: rom_addr = lo;
			T_UPD:   rom_addr = lo;
			default: rom_addr = 7'd0;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= T_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (upd_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				T_IDLE: begin
					if (accept) begin
						st_q <= T_SCALE;
					end
				end
				T_SCALE: begin
					if (scale_done) begin
						st_q <= T_SRCH0;
					end
				end
				T_SRCH0: begin
					st_q <= T_SRCH;
				end
				T_SRCH: begin
					if (cmp_idx_q >= LIMIT_IDX || rom_data >= volt_q) begin
						st_q <= T_LOWRD;
					end
				end
				T_LOWRD: begin
					st_q <= T_UPD;
				end
				T_UPD: begin
					if (upd_go) begin
						st_q <= T_IDLE;
					end
				end
				default: begin
					st_q <= T_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= s_tdata[15:13];
			connected_q <= s_tdata[16];
		end
		if (st_q == T_SCALE && scale_done) begin
			volt_q <= scale_volt;
		end
		if (st_q == T_SRCH0) begin
			cmp_idx_q <= 7'd0;
		end
		if (st_q == T_SRCH) begin
			if (cmp_idx_q >= LIMIT_IDX || rom_data >= volt_q) begin
				pct_q <= (cmp_idx_q > PERCENT_MAX) ? PERCENT_MAX : cmp_idx_q;
			end else begin
				cmp_idx_q <= cmp_idx_q + 7'd1;
			end
		end
		if (upd_go) begin
			m_tdata_q <= {5'd0, present, changed, held_n, p_n, v, next_st};
		end
	end

	// state update, rom_data holds curve[lo] here
	always_comb begin
		en      = (status_q == CHG_CHARGING) || (status_q == CHG_CHARGED);
		present = en ? 1'b1 : connected_q;
		v       = volt_q;
		if (status_q == CHG_READ_FAIL || status_q == CHG_FAULT) begin
			v = 16'd0;
		end
		p_n     = pct_q;
		held_n  = mem_rd.held_level;
		changed = 1'b0;
		next_st = ST_DISCHARGING;
		case (mem_rd.state)
			ST_DISCHARGING: begin
				if (v <= shutoff_mv_q) begin
					p_n     = lo + 7'd1;
					next_st = ST_FAIL;
				end else if (v <= rom_data) begin
					next_st = ST_LOW;
				end else if (en) begin
					next_st = ST_CHARGING;
				end else begin
					if (pct_q < mem_rd.held_level) begin
						held_n  = pct_q;
						changed = 1'b1;
					end else begin
						p_n = mem_rd.held_level;
					end
					next_st = ST_DISCHARGING;
				end
			end
			ST_CHARGING: begin
				if (pct_q >= mem_rd.held_level) begin
					held_n  = ON_CHARGER_LEVEL;
					changed = 1'b1;
				end
				if (en) begin
					if (status_q == CHG_CHARGED) begin
						held_n  = ON_CHARGER_LEVEL;
						p_n     = PERCENT_MAX;
						next_st = ST_CHARGED;
					end else begin
						next_st = ST_CHARGING;
					end
				end else begin
					next_st = ST_DISCHARGING;
				end
			end
			ST_CHARGED: begin
				held_n  = ON_CHARGER_LEVEL;
				p_n     = PERCENT_MAX;
				next_st = en ? ST_CHARGED : ST_DISCHARGING;
			end
			ST_LOW: begin
				if (en) begin
					held_n  = pct_q;
					next_st = ST_CHARGING;
				end else if ({1'b0, pct_q} > ({1'b0, lo} + 8'd2)) begin
					held_n  = pct_q;
					next_st = ST_DISCHARGING;
				end else begin
					p_n     = lo;
					next_st = ST_LOW;
				end
			end
			ST_FAIL: begin
				if ({1'b0, v} > ({1'b0, shutoff_mv_q} + FAIL_HYSTERESIS_MV)) begin
					held_n  = pct_q;
					next_st = ST_DISCHARGING;
				end else begin
					p_n = en ? PERCENT_MAX : (lo + 7'd1);
					if (p_n != mem_rd.held_level) begin
						held_n  = p_n;
						changed = 1'b1;
					end
					next_st = ST_FAIL;
				end
			end
			default: begin
				held_n  = pct_q;
				next_st = ST_DISCHARGING;
			end
		endcase
		mem_wr.state      = next_st;
		mem_wr.held_level = held_n;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_mem_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we))
		else $error("state memory read and write in the same cycle");

	a_scale_done_in_scale: assert property (@(posedge clk) disable iff (!arst_n)
		scale_done |-> (st_q == T_SCALE))
		else $error("scale result arrived outside the scale wait");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:19] <= PERCENT_MAX && m_tdata[32:26] <= ON_CHARGER_LEVEL))
		else $error("percent or reported level out of range");

	a_upd_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		upd_go |=> m_tvalid)
		else $error("update did not load the output register");

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for battery_charge_state_monitor. Starts with a short
// table of ADC samples after reset, with a few results typed in. Then runs
// random discharge, charge and charged runs plus noise under several register
// settings. Typed rows are held to their typed results, the rest to an in-bench
// copy of the conversion, curve lookup and charge state machine. Both stream
// sides idle at random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_top
	import bcsm_pkg::*;
();

	localparam int N_DIRECTED  = 25;
	localparam int N_SETTINGS  = 6;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	// charger status codes outside the defined set
	localparam logic [2:0] CHG_UNDEF_5 = 3'd5;
	localparam logic [2:0] CHG_UNDEF_6 = 3'd6;
	localparam logic [2:0] CHG_UNDEF_7 = 3'd7;

	typedef struct packed {
		logic        charger_present;
		logic        level_changed;
		logic [6:0]  reported_level;
		logic [6:0]  percent_remaining;
		logic [15:0] voltage_mv;
		logic [2:0]  battery_state;
	} reading_t;

	typedef struct packed {
		logic [12:0] adc_count;
		logic [2:0]  charger_status;
		logic        charger_connected;
		logic        typed;
		reading_t    outcome;
	} sample_row_t;

	typedef struct {
		logic [19:0] gain;
		logic [19:0] divisor;
		logic [6:0]  low_idx;
		logic [15:0] shutoff;
		int          n_items;
	} setting_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [12:0] adc_count, [15:13] charger_status, [16] charger_connected
	logic [23:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [2:0] battery_state, [18:3] voltage_mv, [25:19] percent_remaining,
	// [32:26] reported_level, [33] level_changed, [34] charger_present
	logic [39:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_wdata = '0;

	// bench copy of registers and monitor state
	logic [19:0] gain_r = 20'd7200;
	logic [19:0] div_r = 20'd4096;
	logic [6:0]  low_r = 7'd2;
	logic [15:0] shutoff_r = 16'd2600;
	logic [2:0]  mon_state = ST_DISCHARGING;
	logic [6:0]  mon_level = ON_CHARGER_LEVEL;

	reading_t pending_q[$];
	int       n_errors = 0;
	int       quiet_cycles = 0;
	int       sender_gap = 0;
	int       recv_stall = 0;
	bit       hold_req = 1'b0;
	int       walk_mv = 4100;
	int       walk_mode = 0;

	battery_charge_state_monitor uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic reading_t predict_reading(logic [12:0] adc, logic [2:0] status,
			logic conn);
		reading_t        r;
		logic [6:0]      lo;
		logic [6:0]      p;
		logic [2:0]      state_after;
		logic [15:0]     v;
		longint unsigned q;
		logic            en;
		logic            present;
		logic            changed;
		int              i;
		lo = (low_r > LOW_INDEX_MAX) ? LOW_INDEX_MAX : low_r;
		v = '0;
		changed = 1'b0;
		if (!adc[12]) begin
			q = longint'(adc[11:0]) * gain_r / ((div_r == '0) ? 20'd1 : div_r);
			v = (q > 64'hFFFF) ? VOLT_SAT : q[15:0];
		end
		i = 0;
		while (i < CURVE_LEN && CURVE_MV[i] < v)
			i++;
		p = (i > 100) ? PERCENT_MAX : 7'(i);
		if (status == CHG_CHARGING || status == CHG_CHARGED) begin
			present = 1'b1;
			en = 1'b1;
		end else begin
			present = conn;
			en = 1'b0;
			if (status == CHG_READ_FAIL || status == CHG_FAULT)
				v = '0;
		end
		case (mon_state)
			ST_DISCHARGING: begin
				if (v <= shutoff_r) begin
					p = lo + 7'd1;
					state_after = ST_FAIL;
				end else if (v <= CURVE_MV[lo]) begin
					state_after = ST_LOW;
				end else if (en) begin
					state_after = ST_CHARGING;
				end else begin
					if (p < mon_level) begin
						mon_level = p;
						changed = 1'b1;
					end else begin
						p = mon_level;
					end
					state_after = ST_DISCHARGING;
				end
			end
			ST_CHARGING: begin
				if (p >= mon_level) begin
					mon_level = ON_CHARGER_LEVEL;
					changed = 1'b1;
				end
				if (!en) begin
					state_after = ST_DISCHARGING;
				end else if (status == CHG_CHARGED) begin
					mon_level = ON_CHARGER_LEVEL;
					p = PERCENT_MAX;
					state_after = ST_CHARGED;
				end else begin
					state_after = ST_CHARGING;
				end
			end
			ST_CHARGED: begin
				mon_level = ON_CHARGER_LEVEL;
				p = PERCENT_MAX;
				state_after = en ? ST_CHARGED : ST_DISCHARGING;
			end
			ST_LOW: begin
				if (en) begin
					mon_level = p;
					state_after = ST_CHARGING;
				end else if (p > lo + 7'd2) begin
					mon_level = p;
					state_after = ST_DISCHARGING;
				end else begin
					p = lo;
					state_after = ST_LOW;
				end
			end
			ST_FAIL: begin
				if ({1'b0, v} > {1'b0, shutoff_r} + FAIL_HYSTERESIS_MV) begin
					mon_level = p;
					state_after = ST_DISCHARGING;
				end else begin
					p = en ? PERCENT_MAX : lo + 7'd1;
					if (p != mon_level) begin
						mon_level = p;
						changed = 1'b1;
					end
					state_after = ST_FAIL;
				end
			end
			default: begin
				mon_level = p;
				state_after = ST_DISCHARGING;
			end
		endcase
		mon_state = state_after;
		r.battery_state = mon_state;
		r.voltage_mv = v;
		r.percent_remaining = p;
		r.reported_level = mon_level;
		r.level_changed = changed;
		r.charger_present = present;
		return r;
	endfunction

	task automatic send_sample(input logic [12:0] adc, input logic [2:0] status,
			input logic conn, input logic typed, input reading_t typed_res);
		reading_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < sender_gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata <= {7'd0, conn, status, adc};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = predict_reading(adc, status, conn);
		pending_q.push_back(typed ? typed_res : predicted);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SCALE_GAIN:    gain_r = val;
			REG_SCALE_DIVISOR: div_r = val;
			REG_LOW_INDEX:     low_r = val[6:0];
			REG_SHUTOFF_MV:    shutoff_r = val[15:0];
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly battery-like runs (discharge, charge, charged, plugged idle), some noise
	task automatic make_sample(output logic [12:0] adc, output logic [2:0] status,
			output logic conn);
		longint unsigned cnt;
		if ($urandom_range(99) < 20) begin
			adc = 13'($urandom);
			status = 3'($urandom);
			conn = 1'($urandom);
		end else begin
			if ($urandom_range(99) < 5)
				walk_mode = $urandom_range(5);
			status = CHG_READY;
			conn = 1'b0;
			case (walk_mode)
				3: begin
					walk_mv += int'($urandom_range(12));
					status = CHG_CHARGING;
					conn = 1'($urandom);
				end
				4: begin
					walk_mv += int'($urandom_range(3));
					status = CHG_CHARGED;
				end
				5: begin
					walk_mv += int'($urandom_range(6)) - 3;
					conn = 1'b1;
				end
				default: walk_mv -= int'($urandom_range(20));
			endcase
			if (walk_mv < 2400 || walk_mv > 4300)
				walk_mv = $urandom_range(4200, 2500);
			cnt = (longint'(walk_mv) * ((div_r == '0) ? 20'd1 : div_r) + gain_r - 1) / gain_r;
			adc = (cnt > 4095) ? 13'd4095 : 13'(cnt);
		end
	endtask

	initial begin
		sample_row_t rows [N_DIRECTED];
		setting_t    settings [N_SETTINGS];
		logic [12:0] adc;
		logic [2:0]  status;
		logic        conn;
		int          n;
		rows = '{
			'{13'd0, CHG_READY, 1'b0, 1'b1,
				'{charger_present: 1'b0, level_changed: 1'b0, reported_level: 7'd101,
				percent_remaining: 7'd3, voltage_mv: 16'd0, battery_state: ST_FAIL}},
			'{13'd0, CHG_READ_FAIL, 1'b1, 1'b1,
				'{charger_present: 1'b1, level_changed: 1'b1, reported_level: 7'd3,
				percent_remaining: 7'd3, voltage_mv: 16'd0, battery_state: ST_FAIL}},
			'{13'd4095, CHG_FAULT, 1'b0, 1'b1,
				'{charger_present: 1'b0, level_changed: 1'b0, reported_level: 7'd3,
				percent_remaining: 7'd3, voltage_mv: 16'd0, battery_state: ST_FAIL}},
			'{13'd4095, CHG_READY, 1'b1, 1'b1,
				'{charger_present: 1'b1, level_changed: 1'b0, reported_level: 7'd100,
				percent_remaining: 7'd100, voltage_mv: 16'd7198,
				battery_state: ST_DISCHARGING}},
			'{13'd2200, CHG_READY, 1'b0, 1'b0, '0},
			'{13'd2100, CHG_READY, 1'b0, 1'b0, '0},
			'{13'd2100, CHG_CHARGING, 1'b1, 1'b0, '0},
			'{13'd2250, CHG_CHARGING, 1'b0, 1'b0, '0},
			'{13'd2300, CHG_CHARGED, 1'b0, 1'b0, '0},
			'{13'd2300, CHG_UNDEF_5, 1'b1, 1'b0, '0},
			'{13'd1850, CHG_UNDEF_6, 1'b0, 1'b0, '0},
			'{13'd1860, CHG_UNDEF_7, 1'b0, 1'b0, '0},
			'{13'd2200, CHG_CHARGING, 1'b0, 1'b0, '0},
			'{13'h1FFF, CHG_READY, 1'b0, 1'b0, '0},
			'{13'h1000, CHG_READY, 1'b0, 1'b0, '0},
			'{13'd1508, CHG_READY, 1'b0, 1'b0, '0},
			'{13'd1510, CHG_READY, 1'b1, 1'b0, '0},
			'{13'd1479, CHG_READY, 1'b0, 1'b0, '0},
			'{13'd0, CHG_CHARGING, 1'b1, 1'b0, '0},
			'{13'd2000, CHG_CHARGED, 1'b1, 1'b0, '0},
			'{13'd4095, CHG_CHARGING, 1'b1, 1'b0, '0},
			'{13'd4095, CHG_CHARGED, 1'b0, 1'b0, '0},
			'{13'd1000, CHG_CHARGED, 1'b1, 1'b0, '0},
			'{13'd1000, CHG_READ_FAIL, 1'b1, 1'b0, '0},
			'{13'd2048, CHG_FAULT, 1'b1, 1'b0, '0}
		};
		// gain, divisor, low index, shutoff, items
		settings = '{
			'{20'd7200, 20'd4096, 7'd2, 16'd2600, 300},
			'{20'hFFFFF, 20'd0, 7'd97, 16'hFFFF, 60},
			'{20'd1, 20'hFFFFF, 7'd0, 16'd0, 60},
			'{20'd1, 20'd1, 7'd127, 16'd3500, 200},
			'{20'd9000, 20'd4096, 7'd40, 16'd3000, 200},
			'{20'd7200, 20'd4096, 7'd0, 16'd1, 280}
		};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[k])
			send_sample(rows[k].adc_count, rows[k].charger_status, rows[k].charger_connected,
				rows[k].typed, rows[k].outcome);
		wait_drained();

		foreach (settings[s]) begin
			write_reg(REG_SCALE_GAIN, settings[s].gain);
			write_reg(REG_SCALE_DIVISOR, settings[s].divisor);
			write_reg(REG_LOW_INDEX, 20'(settings[s].low_idx));
			write_reg(REG_SHUTOFF_MV, 20'(settings[s].shutoff));
			for (n = 0; n < settings[s].n_items; n++) begin
				case ((n / 40) % 4)
					0: begin sender_gap = 0;  recv_stall = 0;  end
					1: begin sender_gap = 46; recv_stall = 0;  end
					2: begin sender_gap = 0;  recv_stall = 46; end
					default: begin sender_gap = 25; recv_stall = 25; end
				endcase
				if (s == 0 && n == 150)
					hold_req = 1'b1;
				make_sample(adc, status, conn);
				send_sample(adc, status, conn, 1'b0, '0);
			end
			wait_drained();
		end

		repeat (130) @(posedge clk);
		if (n_errors == 0 && pending_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	// output side ready; a hold request blocks it for a long stretch
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		reading_t got;
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[34:0];
			if (pending_q.size() == 0) begin
				$error("result beat with nothing pending: %h", m_tdata);
				n_errors++;
			end else begin
				want = pending_q.pop_front();
				if (got.battery_state !== want.battery_state) begin
					$error("battery_state: expected %0d, got %0d", want.battery_state,
						got.battery_state);
					n_errors++;
				end
				if (got.voltage_mv !== want.voltage_mv) begin
					$error("voltage_mv: expected %0d, got %0d", want.voltage_mv,
						got.voltage_mv);
					n_errors++;
				end
				if (got.percent_remaining !== want.percent_remaining) begin
					$error("percent_remaining: expected %0d, got %0d",
						want.percent_remaining, got.percent_remaining);
					n_errors++;
				end
				if (got.reported_level !== want.reported_level) begin
					$error("reported_level: expected %0d, got %0d", want.reported_level,
						got.reported_level);
					n_errors++;
				end
				if (got.level_changed !== want.level_changed) begin
					$error("level_changed: expected %0d, got %0d", want.level_changed,
						got.level_changed);
					n_errors++;
				end
				if (got.charger_present !== want.charger_present) begin
					$error("charger_present: expected %0d, got %0d", want.charger_present,
						got.charger_present);
					n_errors++;
				end
			end
		end
	end

	// watchdog: too long without a beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

FILE: battery_charge_state_monitor.f
hw/rtl/bcsm_pkg.sv
hw/rtl/bcsm_curve_rom.sv
hw/rtl/bcsm_state_mem.sv
hw/rtl/bcsm_scale.sv
hw/rtl/battery_charge_state_monitor.sv
tb/sv/tb_top.sv
